FILE: hw/rtl/mcc_pkg.sv
// mcc_pkg: shared types and constants for the minimum coin count block
// used by mcc_ctrl, mcc_dp and the top level
package mcc_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_DIV_C2R,
    ST_DIV_C3R,
    ST_INV_START,
    ST_INV_WAIT,
    ST_LIM,
    ST_LOOP,
    ST_REM,
    ST_D2,
    ST_D3,
    ST_VG,
    ST_LO,
    ST_HI,
    ST_TOP,
    ST_Q3LO,
    ST_Q3HI,
    ST_NEXT,
    ST_DONE
  } mcc_state_t;

  typedef enum logic [3:0] {
    DIV_NONE,
    DIV_LIM,
    DIV_REM2,
    DIV_GCD,
    DIV_C2R,
    DIV_C3R,
    DIV_INV,
    DIV_RESTG,
    DIV_TOP,
    DIV_LOMOD,
    DIV_LOPROD,
    DIV_HI,
    DIV_Q3LO,
    DIV_Q3HI
  } mcc_div_sel_t;

  typedef struct packed {
    logic         load;
    logic         div_start;
    mcc_div_sel_t div_sel;
    logic         div_capture;
    logic         gcd_step;
    logic         inv_init;
    logic         inv_step;
    logic         x1_clear;
    logic         x1_inc;
    logic         keep2;
    logic         keep_lo;
    logic         keep_hi;
    logic         out_load;
  } mcc_cmd_t;

  typedef struct packed {
    logic       div_busy;
    logic [1:0] count;
    logic       zero_coef;
    logic       gcd_done;
    logic       inv_done;
    logic       x1_over;
    logic       rem_zero;
    logic       c3r_one;
    logic       lo_gt_top;
    logic       hi_ne_lo;
  } mcc_sts_t;

endpackage

FILE: hw/rtl/mcc_div.sv
// mcc_div: restoring divider, one quotient bit per cycle
// depends on nothing beyond its parameter
module mcc_div #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  q_r, q_nxt, r_r, r_nxt, d_r;
  logic [W:0]    trial;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    r_nxt   = r_r;
    trial   = {r_r, q_r[W-1]};
    if (start) begin
      cnt_nxt = CW'(W);
      q_nxt   = dividend;
      r_nxt   = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, d_r}) begin
        r_nxt = W'(trial - {1'b0, d_r});
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign busy = (cnt_r != '0) || start;
  assign quot = q_r;
  assign rem  = r_r;
endmodule

FILE: hw/rtl/mcc_dp.sv
// mcc_dp: datapath registers, shared divider, gcd and inverse steps
// depends on mcc_pkg and mcc_div
module mcc_dp #(
  parameter int VALUE_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mcc_pkg::mcc_cmd_t cmd,
  output mcc_pkg::mcc_sts_t sts,
  input  logic [1:0]        in_count,
  input  logic [19:0]       in_c1,
  input  logic [19:0]       in_c2,
  input  logic [19:0]       in_c3,
  input  logic [19:0]       in_v,
  output logic              res_found,
  output logic [19:0]       res_total
);
  import mcc_pkg::*;
  localparam int V  = VALUE_BITS;
  localparam int DW = 2 * V;
  localparam int SW = V + 2;

  logic [1:0]   n_r;
  logic [V-1:0] c1_r, c2_r, c3_r, v_r;
  logic [V-1:0] g_r, gb_r, c2r_r, c3r_r, inv_r, lim_r, rest_r;
  logic [V:0]   x1_r;
  logic [V-1:0] top_r, lo_r, hi_r, vg_r, q_r, rr_r;
  logic signed [SW-1:0] ir0_r, ir1_r, is0_r, is1_r;
  logic [V:0]   x1e;
  logic         have_r, fnd_r;
  logic [DW-1:0] best_r, cand, prod_r;
  logic [19:0]  tot_r;
  logic [DW-1:0] dd, ds;
  logic         dbusy;
  logic [DW-1:0] dq, drm;

  mcc_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dd), .divisor(ds),
    .busy(dbusy), .quot(dq), .rem(drm)
  );

  assign rest_r = V'({V'(0), v_r} - DW'(c1_r) * DW'(x1_r));

  always_comb begin
    dd = '0;
    ds = DW'(1);
    unique case (cmd.div_sel)
      DIV_LIM:    begin dd = DW'(v_r);    ds = DW'(c1_r); end
      DIV_REM2:   begin dd = DW'(rest_r); ds = DW'(c2_r); end
      DIV_GCD:    begin dd = DW'(g_r);    ds = DW'(gb_r); end
      DIV_C2R:    begin dd = DW'(c2_r);   ds = DW'(g_r); end
      DIV_C3R:    begin dd = DW'(c3_r);   ds = DW'(g_r); end
      DIV_INV:    begin dd = DW'(ir0_r[V-1:0]); ds = DW'(ir1_r[V-1:0]); end
      DIV_RESTG:  begin dd = DW'(rest_r); ds = DW'(g_r); end
      DIV_TOP:    begin dd = DW'(rest_r); ds = DW'(c2_r); end
      DIV_LOMOD:  begin dd = DW'(vg_r);   ds = DW'(c3r_r); end
      DIV_LOPROD: begin dd = prod_r;      ds = DW'(c3r_r); end
      DIV_HI:     begin dd = DW'(top_r - lo_r); ds = DW'(c3r_r); end
      DIV_Q3LO:   begin dd = DW'(rest_r) - DW'(c2_r) * DW'(lo_r); ds = DW'(c3_r); end
      DIV_Q3HI:   begin dd = DW'(rest_r) - DW'(c2_r) * DW'(hi_r); ds = DW'(c3_r); end
      default:    begin dd = '0; ds = DW'(1); end
    endcase
  end

  always_comb begin
    cand = DW'(x1_r) + DW'(q_r);
    if (cmd.keep_lo) cand = DW'(x1_r) + DW'(lo_r) + dq;
    if (cmd.keep_hi) cand = DW'(x1_r) + DW'(hi_r) + dq;
    if (cmd.keep2)   cand = DW'(x1_r) + dq;
  end

  assign x1e = x1_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= in_count;
      c1_r <= V'(in_c1);
      c2_r <= V'(in_c2);
      c3_r <= V'(in_c3);
      v_r  <= V'(in_v);
      g_r  <= V'(in_c2);
      gb_r <= V'(in_c3);
      have_r <= 1'b0;
      best_r <= '0;
    end
    if (cmd.gcd_step) begin
      g_r  <= gb_r;
      gb_r <= V'(drm);
    end
    if (cmd.div_capture) begin
      unique case (cmd.div_sel)
        DIV_LIM:    begin lim_r <= V'(dq); rr_r <= V'(drm); end
        DIV_REM2:   rr_r  <= V'(drm);
        DIV_C2R:    c2r_r <= V'(dq);
        DIV_C3R:    c3r_r <= V'(dq);
        DIV_RESTG:  begin rr_r <= V'(drm); vg_r <= V'(dq); end
        // lo and hi start as the full range, which stands when c3r is one
        DIV_TOP:    begin top_r <= V'(dq); lo_r <= '0; hi_r <= V'(dq); end
        DIV_LOMOD:  prod_r <= DW'(V'(drm)) * DW'(inv_r);
        DIV_LOPROD: lo_r  <= V'(drm);
        DIV_HI:     hi_r  <= V'(DW'(lo_r) + DW'(dq[V-1:0]) * DW'(c3r_r));
        default:    q_r   <= V'(dq);
      endcase
    end
    if (cmd.inv_init) begin
      ir0_r <= SW'(c2r_r);
      ir1_r <= SW'(c3r_r);
      is0_r <= SW'(1);
      is1_r <= '0;
      inv_r <= '0;
    end
    if (cmd.inv_step) begin
      ir0_r <= ir1_r;
      ir1_r <= SW'(drm);
      is0_r <= is1_r;
      is1_r <= SW'(is0_r - SW'(dq) * is1_r);
    end
    if (sts.inv_done && !cmd.inv_init) begin
      inv_r <= (is0_r < 0) ? V'(is0_r + SW'(c3r_r)) : V'(is0_r);
    end
    if (cmd.x1_clear) x1_r <= '0;
    if (cmd.x1_inc)   x1_r <= x1_r + 1'b1;
    if (cmd.keep2 || cmd.keep_lo || cmd.keep_hi) begin
      if (!have_r || cand < best_r) begin
        best_r <= cand;
        have_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      fnd_r <= have_r;
      tot_r <= have_r ? 20'(best_r) : '0;
    end
  end

  assign sts.div_busy  = dbusy;
  assign sts.count     = n_r;
  assign sts.zero_coef = (c1_r == '0) || (n_r >= 2'd2 && c2_r == '0) ||
                         (n_r == 2'd3 && c3_r == '0);
  assign sts.gcd_done  = (gb_r == '0);
  assign sts.inv_done  = (ir1_r == '0);
  assign sts.x1_over   = (x1e > {1'b0, lim_r});
  assign sts.rem_zero  = (rr_r == '0);
  assign sts.c3r_one   = (c3r_r == V'(1));
  assign sts.lo_gt_top = (lo_r > top_r);
  assign sts.hi_ne_lo  = (hi_r != lo_r);
  assign res_found = fnd_r;
  assign res_total = tot_r;
endmodule

FILE: hw/rtl/mcc_ctrl.sv
// mcc_ctrl: sequencer for one problem at a time
// depends on mcc_pkg
module mcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output mcc_pkg::mcc_cmd_t cmd,
  input  mcc_pkg::mcc_sts_t sts
);
  import mcc_pkg::*;
  mcc_state_t st_r, st_nxt;
  mcc_div_sel_t sel_r, sel_nxt;
  logic wait_r, wait_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      sel_r  <= DIV_NONE;
      wait_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      sel_r  <= sel_nxt;
      wait_r <= wait_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    sel_nxt  = sel_r;
    wait_nxt = wait_r;
    cmd      = '0;
    cmd.div_sel = sel_r;
    busy     = (st_r != ST_IDLE);
    done     = 1'b0;
    // divide: issue in one cycle, then wait until the divider drains
    if (wait_r) begin
      if (!sts.div_busy) begin
        wait_nxt = 1'b0;
        cmd.div_capture = (st_r != ST_GCD_WAIT) && (st_r != ST_INV_WAIT) &&
                          (st_r != ST_Q3LO) && (st_r != ST_Q3HI) &&
                          (st_r != ST_REM);
        unique case (st_r)
          ST_LIM:      st_nxt = ST_LOOP;
          ST_GCD_WAIT: begin cmd.gcd_step = 1'b1; st_nxt = ST_GCD_START; end
          ST_DIV_C2R:  st_nxt = ST_DIV_C3R;
          ST_DIV_C3R:  st_nxt = ST_INV_START;
          ST_INV_WAIT: begin cmd.inv_step = 1'b1; st_nxt = ST_INV_WAIT; end
          ST_REM: begin
            cmd.div_capture = 1'b1;
            if (sel_r == DIV_REM2) begin
              st_nxt = ST_D2;
            end else begin
              st_nxt = ST_VG;
            end
          end
          ST_D2:   begin cmd.keep2 = 1'b1; st_nxt = ST_NEXT; end
          ST_TOP:  st_nxt = sts.c3r_one ? ST_HI : ST_LO;
          ST_LO:   st_nxt = (sel_r == DIV_LOMOD) ? ST_LO : ST_HI;
          ST_HI:   st_nxt = ST_Q3LO;
          ST_Q3LO: begin cmd.keep_lo = 1'b1; st_nxt = ST_Q3HI; end
          ST_Q3HI: begin cmd.keep_hi = 1'b1; st_nxt = ST_NEXT; end
          default: st_nxt = st_r;
        endcase
        // follow-on divide inside one state
        if (st_r == ST_LO && sel_r == DIV_LOMOD) begin
          sel_nxt = DIV_LOPROD;
        end
      end
    end else begin
      unique case (st_r)
        ST_IDLE: if (start) begin cmd.load = 1'b1; st_nxt = ST_CHECK; end
        ST_CHECK: begin
          cmd.x1_clear = 1'b1;
          if (sts.zero_coef || sts.count == 2'd0) begin
            st_nxt = ST_DONE;
          end else if (sts.count == 2'd3) begin
            st_nxt = ST_GCD_START;
          end else begin
            st_nxt = ST_LIM;
            sel_nxt = DIV_LIM;
            cmd.div_sel = DIV_LIM;
            cmd.div_start = 1'b1;
            wait_nxt = 1'b1;
          end
        end
        ST_GCD_START: begin
          if (sts.gcd_done) begin
            st_nxt = ST_DIV_C2R; sel_nxt = DIV_C2R; cmd.div_sel = DIV_C2R;
          end else begin
            st_nxt = ST_GCD_WAIT; sel_nxt = DIV_GCD; cmd.div_sel = DIV_GCD;
          end
          cmd.div_start = 1'b1;
          wait_nxt = 1'b1;
        end
        ST_DIV_C3R: begin
          sel_nxt = DIV_C3R; cmd.div_sel = DIV_C3R;
          cmd.div_start = 1'b1; wait_nxt = 1'b1;
        end
        ST_INV_START: begin
          cmd.inv_init = 1'b1;
          st_nxt = ST_INV_WAIT;
        end
        ST_INV_WAIT: begin
          if (sts.inv_done) begin
            st_nxt = ST_LIM; sel_nxt = DIV_LIM; cmd.div_sel = DIV_LIM;
          end else begin
            sel_nxt = DIV_INV; cmd.div_sel = DIV_INV;
          end
          cmd.div_start = 1'b1; wait_nxt = 1'b1;
        end
        ST_LOOP: begin
          if (sts.x1_over) begin
            st_nxt = ST_DONE;
          end else if (sts.count == 2'd1) begin
            // quotient and remainder of target / coef_first still in the divider
            st_nxt = ST_D2;
          end else begin
            st_nxt = ST_REM;
            if (sts.count == 2'd2) begin
              sel_nxt = DIV_REM2; cmd.div_sel = DIV_REM2;
            end else begin
              sel_nxt = DIV_RESTG; cmd.div_sel = DIV_RESTG;
            end
            cmd.div_start = 1'b1; wait_nxt = 1'b1;
          end
        end
        ST_D2: begin
          // one coefficient: divisibility only; two: remainder checked, quotient next
          if (sts.count == 2'd1) begin
            cmd.keep2 = sts.rem_zero;
            st_nxt = ST_DONE;
          end else if (!sts.rem_zero) begin
            st_nxt = ST_NEXT;
          end else begin
            sel_nxt = DIV_TOP; cmd.div_sel = DIV_TOP;
            cmd.div_start = 1'b1; wait_nxt = 1'b1;
          end
        end
        ST_VG: begin
          if (!sts.rem_zero) begin
            st_nxt = ST_NEXT;
          end else begin
            st_nxt = ST_TOP; sel_nxt = DIV_TOP; cmd.div_sel = DIV_TOP;
            cmd.div_start = 1'b1; wait_nxt = 1'b1;
          end
        end
        ST_LO: begin
          if (sel_r == DIV_LOPROD) begin
            cmd.div_sel = DIV_LOPROD;
          end else begin
            sel_nxt = DIV_LOMOD; cmd.div_sel = DIV_LOMOD;
          end
          cmd.div_start = 1'b1; wait_nxt = 1'b1;
        end
        ST_HI: begin
          if (sts.c3r_one) begin
            cmd.div_capture = 1'b0;
            st_nxt = ST_Q3LO; sel_nxt = DIV_Q3LO; cmd.div_sel = DIV_Q3LO;
            cmd.div_start = 1'b1; wait_nxt = 1'b1;
          end else if (sts.lo_gt_top) begin
            st_nxt = ST_NEXT;
          end else begin
            sel_nxt = DIV_HI; cmd.div_sel = DIV_HI;
            cmd.div_start = 1'b1; wait_nxt = 1'b1;
          end
        end
        ST_Q3LO: begin
          sel_nxt = DIV_Q3LO; cmd.div_sel = DIV_Q3LO;
          cmd.div_start = 1'b1; wait_nxt = 1'b1;
        end
        ST_Q3HI: begin
          if (sts.hi_ne_lo) begin
            sel_nxt = DIV_Q3HI; cmd.div_sel = DIV_Q3HI;
            cmd.div_start = 1'b1; wait_nxt = 1'b1;
          end else begin
            st_nxt = ST_NEXT;
          end
        end
        ST_NEXT: begin cmd.x1_inc = 1'b1; st_nxt = ST_LOOP; end
        ST_DONE: begin cmd.out_load = 1'b1; done = 1'b1; st_nxt = ST_IDLE; end
        default: st_nxt = ST_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/min_coin_count_three_denoms_top.sv
// min_coin_count_three_denoms_top: stream wrapper, controller and datapath
// depends on mcc_pkg, mcc_ctrl, mcc_dp
//
// One problem in, one result out. Every division runs on one shared
// bit-serial divider. One coefficient needs a single division. Two
// and three coefficients sweep every first multiplier x1 from 0 to
// target / coef_first; each step takes up to two divisions for two
// coefficients and up to seven for three, after a setup of one
// division per gcd step and per inverse step plus three more. With
// coef_first of 1 and a full-range target that is about 2^VALUE_BITS steps.
// The next problem is taken only after the previous result has been
// transferred out.
module min_coin_count_three_denoms_top #(
  parameter int VALUE_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // coef_count[1:0], coef_first[21:2], coef_second[41:22],
  // coef_third[61:42], target_value[81:62], zero fill to 88
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // found[0], min_total[20:1], zero fill to 24
  output logic [23:0] out_tdata
);
  import mcc_pkg::*;
  mcc_cmd_t cmd;
  mcc_sts_t sts;
  logic busy, done, fnd;
  logic [19:0] tot;
  logic ov_r;
  logic [20:0] od_r;
  logic pend_r;

  // accept while the sequencer idles and no result is pending
  assign in_tready = !busy && !ov_r && !pend_r;

  mcc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_tvalid && in_tready),
    .busy(busy), .done(done), .cmd(cmd), .sts(sts)
  );

  mcc_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_count(in_tdata[1:0]), .in_c1(in_tdata[21:2]), .in_c2(in_tdata[41:22]),
    .in_c3(in_tdata[61:42]), .in_v(in_tdata[81:62]),
    .res_found(fnd), .res_total(tot)
  );

  // output register: done is registered into pend_r, which then loads the result into od_r and raises out_tvalid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= done;
      if (pend_r) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
    if (pend_r) od_r <= {tot, fnd};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'b000, od_r};
endmodule
